### hdl/tlc_pkg.sv
// Shared types and constants for the timestamp LRU entry cache.
package tlc_pkg;

  localparam int DATA_W     = 32;
  localparam int CFG_W      = 6;
  localparam int SLOT_OUT_W = 5;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 6'd32;

  // register index, taken from paddr above the byte offset
  localparam logic REG_MAX_ENTRIES = 1'b0;

  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_INSERT  = 2'd1,
    OUT_MISS_NC = 2'd2,
    OUT_EVICT   = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

endpackage

### hdl/tlc_ram.sv
// Generic single-port-write, registered-read RAM.
module tlc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/timestamp_lru_entry_cache_top.sv
// Fully associative LRU entry cache, keyed by id, with access timestamps.
//
// Input channel (in_valid/in_ready) carries entry_id, current_time and
// kind_cacheable. Each accepted item yields one result (hit, insert or
// non-cacheable miss), preceded on an insert by zero or more eviction records.
// Results leave on out_valid/out_ready; last_of_run marks the final one.
// Keys and stamps live in one RAM; valid bits and the fill count are flops.
// Every access scans all CAPACITY slots through the RAM read port before the
// first result of an item is registered; each eviction beyond the first adds
// another full scan, and after the last eviction the insert record is emitted
// from the decision step without a further scan. One item is processed at a
// time, so a new item is accepted only after the last result of the previous
// one has been registered; in_ready is high only between items, and a waiting
// final result does not block the next item. If the receiver stalls, the block
// holds in its decision step until the output register frees up. Reset (rst,
// synchronous) empties the cache, sets max_entries to 32 and drops any pending
// result. max_entries is written over the APB port at byte address 0 and
// should change only while the block is idle.
module timestamp_lru_entry_cache_top #(
  parameter int CAPACITY = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tlc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tlc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tlc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  // access items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tlc_pkg::DATA_W-1:0]        entry_id,
  input  logic [tlc_pkg::DATA_W-1:0]        current_time,
  input  logic                              kind_cacheable,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output tlc_pkg::outcome_t                 outcome,
  output logic [tlc_pkg::SLOT_OUT_W-1:0]    slot_index,
  output logic [tlc_pkg::DATA_W-1:0]        reported_id,
  output logic                              last_of_run
);

  import tlc_pkg::*;

  localparam int IW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RAM_W = 2 * DATA_W;

  state_t state, state_next;

  logic [CFG_W-1:0]    max_entries;
  logic [CFG_W-1:0]    limit;
  logic [CAPACITY-1:0] valid;
  logic [CNT_W-1:0]    occupied;
  logic [CFG_W-1:0]    occ_ext;

  logic [DATA_W-1:0] req_id;
  logic [DATA_W-1:0] req_time;
  logic              req_cacheable;

  logic [CNT_W-1:0] cnt;
  logic             cmp_valid;
  logic [IW-1:0]    cmp_addr;

  logic              hit_found;
  logic [IW-1:0]     hit_slot;
  logic              old_found;
  logic [IW-1:0]     old_slot;
  logic [DATA_W-1:0] old_stamp;
  logic [DATA_W-1:0] old_key;

  logic [IW-1:0]     free_slot;
  logic              accept, out_free, scan_issue, scan_start, emit;
  logic              need_evict, do_insert, do_hit;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [RAM_W-1:0]  ram_rdata;
  logic [DATA_W-1:0] rd_key, rd_stamp;
  logic [IW+SLOT_OUT_W-1:0] slot_wide;
  logic [IW-1:0]     emit_slot;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RST;
    end else if (psel && penable && pwrite &&
                 paddr[APB_ADDR_W-1:2] == REG_MAX_ENTRIES) begin
      max_entries <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1:2] == REG_MAX_ENTRIES) begin
      prdata = {{(APB_DATA_W-CFG_W){1'b0}}, max_entries};
    end
  end

  // limit of zero acts as one, above capacity acts as capacity
  always_comb begin
    if (max_entries == '0) begin
      limit = CFG_W'(1);
    end else if (max_entries > CFG_W'(CAPACITY)) begin
      limit = CFG_W'(CAPACITY);
    end else begin
      limit = max_entries;
    end
  end

  assign occ_ext = CFG_W'(occupied);

  // ---------------- entry RAM: {key, stamp} ----------------
  tlc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({req_id, req_time}),
    .re    (scan_issue),
    .raddr (cnt[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_key   = ram_rdata[RAM_W-1:DATA_W];
  assign rd_stamp = ram_rdata[DATA_W-1:0];

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = IW'(i);
      end
    end
  end

  // ---------------- control ----------------
  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign scan_issue = (state == ST_SCAN) && (cnt < CNT_W'(CAPACITY));
  assign need_evict = req_cacheable && !hit_found && old_found && (occ_ext >= limit);
  assign do_hit     = hit_found;
  assign do_insert  = !hit_found && req_cacheable && !need_evict;
  assign ram_we     = emit && (do_hit || do_insert);
  assign ram_waddr  = do_hit ? hit_slot : free_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    scan_start = 1'b0;
    emit       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
          scan_start = 1'b1;
        end
      end
      ST_SCAN: begin
        if (cnt == CNT_W'(CAPACITY) && !cmp_valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          emit = 1'b1;
          if (need_evict) begin
            // more evictions needed: search again for the oldest entry
            if (occ_ext - CFG_W'(1) >= limit) begin
              state_next = ST_SCAN;
              scan_start = 1'b1;
            end
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      req_id        <= entry_id;
      req_time      <= current_time;
      req_cacheable <= kind_cacheable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      cmp_valid <= 1'b0;
      hit_found <= 1'b0;
      old_found <= 1'b0;
    end else begin
      cmp_valid <= scan_issue;
      if (scan_start) begin
        cnt       <= '0;
        hit_found <= 1'b0;
        old_found <= 1'b0;
      end else begin
        if (scan_issue) begin
          cnt <= cnt + CNT_W'(1);
        end
        // compare stage, in the cycle after the read is issued
        if (cmp_valid && valid[cmp_addr]) begin
          if (!hit_found && rd_key == req_id) begin
            hit_found <= 1'b1;
          end
          if (!old_found || rd_stamp < old_stamp) begin
            old_found <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      cmp_addr <= cnt[IW-1:0];
    end
    if (!scan_start && cmp_valid && valid[cmp_addr]) begin
      if (!hit_found && rd_key == req_id) begin
        hit_slot <= cmp_addr;
      end
      if (!old_found || rd_stamp < old_stamp) begin
        old_slot  <= cmp_addr;
        old_stamp <= rd_stamp;
        old_key   <= rd_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      occupied <= '0;
    end else if (emit) begin
      if (need_evict) begin
        valid[old_slot] <= 1'b0;
        occupied        <= occupied - CNT_W'(1);
      end else if (do_insert) begin
        valid[free_slot] <= 1'b1;
        occupied         <= occupied + CNT_W'(1);
      end
    end
  end

  // ---------------- result register ----------------
  always_comb begin
    if (do_hit) begin
      emit_slot = hit_slot;
    end else if (!req_cacheable) begin
      emit_slot = '0;
    end else if (need_evict) begin
      emit_slot = old_slot;
    end else begin
      emit_slot = free_slot;
    end
  end

  assign slot_wide = {{SLOT_OUT_W{1'b0}}, emit_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      slot_index <= slot_wide[SLOT_OUT_W-1:0];
      if (do_hit) begin
        outcome     <= OUT_HIT;
        reported_id <= req_id;
        last_of_run <= 1'b1;
      end else if (!req_cacheable) begin
        outcome     <= OUT_MISS_NC;
        reported_id <= req_id;
        last_of_run <= 1'b1;
      end else if (need_evict) begin
        outcome     <= OUT_EVICT;
        reported_id <= old_key;
        last_of_run <= 1'b0;
      end else begin
        outcome     <= OUT_INSERT;
        reported_id <= req_id;
        last_of_run <= 1'b1;
      end
    end
  end

  // ---------------- assertions ----------------
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    occupied == CNT_W'($countones(valid)))
    else $error("fill count differs from number of valid slots");

  a_insert_into_free: assert property (@(posedge clk) disable iff (rst)
    (emit && do_insert) |-> !valid[free_slot])
    else $error("insert targets an occupied slot");

  a_hit_on_valid: assert property (@(posedge clk) disable iff (rst)
    (emit && do_hit) |-> valid[hit_slot])
    else $error("hit refresh targets an empty slot");

  a_evict_valid: assert property (@(posedge clk) disable iff (rst)
    (emit && need_evict) |=> !valid[$past(old_slot)])
    else $error("evicted slot still valid");

endmodule
